FILE: rtl/core/mst_pkg.sv
// Shared constants and types for the multi-slot timer bank.
// No dependencies; imported by every module of the timer.
`default_nettype none

package mst_pkg;

	localparam int SLOTS      = 8;
	localparam int USED_W     = $clog2(SLOTS + 1);
	localparam int MASK_W     = (SLOTS > 8) ? SLOTS : 8;
	localparam int DELAY_W    = 32;
	localparam int IDX_OUT_W  = 3;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_ADD  = 1'b1;

	localparam logic [DELAY_W-1:0] CNT_MAX = {DELAY_W{1'b1}};

	typedef struct packed {
		logic               tick;
		logic               add;
		logic [DELAY_W-1:0] delay;
		logic               repeat_req;
	} cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/multi_slot_software_timer.sv
// Top level of the multi-slot timer: a chain of mst_cell slots and the result register.
// Depends on mst_pkg and mst_cell.
//
// Usage:
//   An item is transferred at a rising edge with start high and busy low. busy is
//   always low: one item may follow another in every cycle.
//   kind = tick advances every armed slot; kind = add claims the next unused slot
//   (slot 0 first) with delay_ticks and repeat_req. Slots are never reused.
//   Each item gives one result, shown for exactly one cycle with done high, in the
//   cycle after the transfer (throughput 1 item per cycle). The slot
//   counters and compares work in parallel, one per cell; the free-slot claim
//   ripples along the cell chain in the same cycle.
//   fired_mask and active_mask carry slots 0 to 7; slot_assigned is the low three
//   bits of the slot index; a rejected add gives add_accepted and slot_assigned 0.
//   The receiver cannot stall: a result not taken in its cycle is gone.
//   Reset disarms and frees all slots and drops done; delays are left as they were.
`default_nettype none

module multi_slot_software_timer (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire                              kind,
	input  wire  [mst_pkg::DELAY_W-1:0]      delay_ticks,
	input  wire                              repeat_req,
	output logic                             done,
	output logic [7:0]                       fired_mask,
	output logic                             add_accepted,
	output logic [mst_pkg::IDX_OUT_W-1:0]    slot_assigned,
	output logic [7:0]                       active_mask
);
	import mst_pkg::*;

	cell_cmd_t          cmd;
	logic               xfer;
	logic [SLOTS:0]     claim;
	logic [SLOTS-1:0]   fired_vec;
	logic [SLOTS-1:0]   armed_vec;
	logic [MASK_W-1:0]  fired_ext;
	logic [MASK_W-1:0]  armed_ext;
	logic               full;
	logic               add_ok;
	logic [USED_W-1:0]  slots_used_q;

	logic               done_q;
	logic [7:0]         fired_mask_q;
	logic               add_accepted_q;
	logic [IDX_OUT_W-1:0] slot_assigned_q;

	assign busy = 1'b0;
	assign xfer = start & ~busy;

	assign cmd.tick       = xfer & (kind == KIND_TICK);
	assign cmd.add        = xfer & (kind == KIND_ADD);
	assign cmd.delay      = delay_ticks;
	assign cmd.repeat_req = repeat_req;

	assign claim[0] = 1'b1;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		mst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.claim_in  (claim[i]),
			.claim_out (claim[i+1]),
			.fired     (fired_vec[i]),
			.armed     (armed_vec[i])
		);
	end

	assign full      = claim[SLOTS];
	assign add_ok    = cmd.add & ~full;
	assign fired_ext = MASK_W'(fired_vec);
	assign armed_ext = MASK_W'(armed_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= xfer;
			if (add_ok) begin
				slots_used_q <= slots_used_q + USED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		fired_mask_q    <= fired_ext[7:0];
		add_accepted_q  <= add_ok;
		slot_assigned_q <= add_ok ? IDX_OUT_W'(slots_used_q) : '0;
	end

	assign done          = done_q;
	assign fired_mask    = fired_mask_q;
	assign add_accepted  = add_accepted_q;
	assign slot_assigned = slot_assigned_q;
	assign active_mask   = armed_ext[7:0];

endmodule

`default_nettype wire

FILE: rtl/core/mst_cell.sv
// One timer slot: delay, saturating counter, repeat flag, armed and used flags.
// Passes the free-slot claim to its right-hand neighbour. Depends on mst_pkg.
`default_nettype none

module mst_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire mst_pkg::cell_cmd_t cmd,
	input  wire                     claim_in,
	output logic                    claim_out,
	output logic                    fired,
	output logic                    armed
);
	import mst_pkg::*;

	logic [DELAY_W-1:0] delay_q;
	logic [DELAY_W-1:0] counter_q;
	logic               repeat_q;
	logic               armed_q;
	logic               used_q;

	logic               take;
	logic [DELAY_W-1:0] cnt_inc;
	logic               hit;

	assign take      = cmd.add & claim_in & ~used_q;
	assign cnt_inc   = (counter_q == CNT_MAX) ? counter_q : counter_q + DELAY_W'(1);
	assign hit       = cmd.tick & armed_q & (cnt_inc >= delay_q);
	assign claim_out = claim_in & used_q;
	assign fired     = hit;
	assign armed     = armed_q;

	always_ff @(posedge clk) begin
		if (take) begin
			delay_q <= cmd.delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			repeat_q  <= 1'b0;
			armed_q   <= 1'b0;
			used_q    <= 1'b0;
		end else if (take) begin
			counter_q <= '0;
			repeat_q  <= cmd.repeat_req;
			armed_q   <= 1'b1;
			used_q    <= 1'b1;
		end else if (cmd.tick && armed_q) begin
			counter_q <= hit ? '0 : cnt_inc;
			if (hit && !repeat_q) begin
				armed_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/mst_checker.sv
// Port-level checks for multi_slot_software_timer, bound to the top level.
// Depends on mst_pkg.
`default_nettype none

module mst_port_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           kind,
	input wire                           done,
	input wire [7:0]                     fired_mask,
	input wire                           add_accepted,
	input wire [mst_pkg::IDX_OUT_W-1:0]  slot_assigned,
	input wire [7:0]                     active_mask
);
	import mst_pkg::*;

	// one result per transfer, in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("transfer without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without transfer");

	a_rejected_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !add_accepted) |-> (slot_assigned == '0))
		else $error("slot index on rejected add or tick");

	a_fire_not_add: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fired_mask != 8'h00) |-> !add_accepted)
		else $error("fire and add in one result");

	// a tick can only disarm slots
	a_tick_no_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_TICK) |=>
			((active_mask & ~$past(active_mask)) == 8'h00))
		else $error("tick armed a slot");

endmodule

bind multi_slot_software_timer mst_port_checker u_mst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.kind          (kind),
	.done          (done),
	.fired_mask    (fired_mask),
	.add_accepted  (add_accepted),
	.slot_assigned (slot_assigned),
	.active_mask   (active_mask)
);

`default_nettype wire
